/* rtl/four_connected_line_stepper_macros.svh */
// assertion macros shared by the line stepper rtl
`ifndef FOUR_CONNECTED_LINE_STEPPER_MACROS_SVH
`define FOUR_CONNECTED_LINE_STEPPER_MACROS_SVH

`ifndef SYNTHESIS
`define FCLS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FCLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FCLS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define FCLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* rtl/fcls_pkg.sv */
// shared types for the four-connected line stepper
`default_nettype none

package fcls_pkg;

  // step directions of one line
  typedef struct packed {
    logic x_neg;
    logic y_neg;
  } dir_t;

  // sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage

`default_nettype wire

/* rtl/fcls_setup.sv */
// spans, directions and initial error of a line request
`default_nettype none

module fcls_setup #(
  parameter int COORD_BITS = 5
) (
  input  wire logic [COORD_BITS-1:0] x0,
  input  wire logic [COORD_BITS-1:0] y0,
  input  wire logic [COORD_BITS-1:0] x1,
  input  wire logic [COORD_BITS-1:0] y1,
  output logic [COORD_BITS-1:0]      span_x,
  output logic [COORD_BITS-1:0]      span_y,
  output fcls_pkg::dir_t             dir,
  output logic [COORD_BITS+2:0]      err_init,
  output logic [COORD_BITS:0]        steps_init
);

  localparam int ERR_W = COORD_BITS + 3;

  always_comb begin
    span_x    = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
    span_y    = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
    dir.x_neg = (x1 <= x0);
    dir.y_neg = (y1 <= y0);
    err_init  = ERR_W'(span_x) - ERR_W'(span_y);
    steps_init = (COORD_BITS+1)'(span_x) + (COORD_BITS+1)'(span_y);
  end

endmodule

`default_nettype wire

/* rtl/fcls_step_unit.sv */
// one bresenham move: error compare, error update and coordinate step
`default_nettype none

module fcls_step_unit #(
  parameter int COORD_BITS = 5
) (
  input  wire logic [COORD_BITS-1:0] walk_x,
  input  wire logic [COORD_BITS-1:0] walk_y,
  input  wire logic [COORD_BITS+2:0] err,
  input  wire logic [COORD_BITS-1:0] span_x,
  input  wire logic [COORD_BITS-1:0] span_y,
  input  wire fcls_pkg::dir_t        dir,
  output logic [COORD_BITS-1:0]      walk_x_next,
  output logic [COORD_BITS-1:0]      walk_y_next,
  output logic [COORD_BITS+2:0]      err_next
);

  localparam int ERR_W = COORD_BITS + 3;

  logic [ERR_W:0]   twice_sum;
  logic             move_x;
  logic [ERR_W-1:0] sx_ext;
  logic [ERR_W-1:0] sy_ext;
  logic [ERR_W-1:0] operand;

  always_comb begin
    sx_ext = ERR_W'(span_x);
    sy_ext = ERR_W'(span_y);
    // 2*err > -span_y  <=>  2*err + span_y > 0
    twice_sum = {err, 1'b0} + (ERR_W+1)'(span_y);
    move_x    = !twice_sum[ERR_W] && (twice_sum != '0);
    operand   = move_x ? (~sy_ext + ERR_W'(1)) : sx_ext;
    err_next  = err + operand;
    walk_x_next = walk_x;
    walk_y_next = walk_y;
    if (move_x) begin
      walk_x_next = dir.x_neg ? (walk_x - COORD_BITS'(1)) : (walk_x + COORD_BITS'(1));
    end else begin
      walk_y_next = dir.y_neg ? (walk_y - COORD_BITS'(1)) : (walk_y + COORD_BITS'(1));
    end
  end

endmodule

`default_nettype wire

/* rtl/four_connected_line_stepper.sv */
// four-connected bresenham line stepper, top level
//
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       start_x, start_y, end_x, end_y
// m_*       out  m_tvalid / m_tready       cell_x, cell_y, last_cell (tlast)
//
// a request of spans dx, dy yields dx+dy+1 cells (63 at most with 5-bit coordinates),
// one per cycle when m_tready stays high; the next request is taken only once
// the sequencer is back in idle after the last cell
// the step unit makes one move per accepted cell but the last; m_tready low holds it
// rst is synchronous and returns the sequencer to idle
`default_nettype none

`include "four_connected_line_stepper_macros.svh"

module four_connected_line_stepper #(
  parameter int COORD_BITS = 5
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // start_x, start_y, end_x, end_y from bit 0 up
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // cell_x, cell_y from bit 0 up
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  output logic      m_tlast
);

  localparam int ERR_W       = COORD_BITS + 3;
  localparam int OUT_TDATA_W = ((2*COORD_BITS+7)/8)*8;

  fcls_pkg::state_t state;
  fcls_pkg::state_t state_next;

  logic [COORD_BITS-1:0] walk_x;
  logic [COORD_BITS-1:0] walk_y;
  logic [ERR_W-1:0]      err;
  logic [COORD_BITS-1:0] span_x;
  logic [COORD_BITS-1:0] span_y;
  fcls_pkg::dir_t        dir;
  logic [COORD_BITS:0]   steps_left;

  logic [COORD_BITS-1:0] setup_span_x;
  logic [COORD_BITS-1:0] setup_span_y;
  fcls_pkg::dir_t        setup_dir;
  logic [ERR_W-1:0]      setup_err;
  logic [COORD_BITS:0]   setup_steps;

  logic [COORD_BITS-1:0] walk_x_next;
  logic [COORD_BITS-1:0] walk_y_next;
  logic [ERR_W-1:0]      err_next;

  logic in_fire;
  logic out_fire;

  fcls_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .x0         (s_tdata[COORD_BITS-1:0]),
    .y0         (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .x1         (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .y1         (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .span_x     (setup_span_x),
    .span_y     (setup_span_y),
    .dir        (setup_dir),
    .err_init   (setup_err),
    .steps_init (setup_steps)
  );

  fcls_step_unit #(.COORD_BITS(COORD_BITS)) u_step (
    .walk_x      (walk_x),
    .walk_y      (walk_y),
    .err         (err),
    .span_x      (span_x),
    .span_y      (span_y),
    .dir         (dir),
    .walk_x_next (walk_x_next),
    .walk_y_next (walk_y_next),
    .err_next    (err_next)
  );

  assign s_tready = (state == fcls_pkg::ST_IDLE);
  assign m_tvalid = (state == fcls_pkg::ST_EMIT);
  assign m_tdata  = OUT_TDATA_W'({walk_y, walk_x});
  assign m_tlast  = (steps_left == '0);
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      fcls_pkg::ST_IDLE: begin
        if (in_fire) state_next = fcls_pkg::ST_EMIT;
      end
      fcls_pkg::ST_EMIT: begin
        if (out_fire && m_tlast) state_next = fcls_pkg::ST_IDLE;
      end
      default: state_next = fcls_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fcls_pkg::ST_IDLE;
      steps_left <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        steps_left <= setup_steps;
      end else if (out_fire && !m_tlast) begin
        steps_left <= steps_left - (COORD_BITS+1)'(1);
      end
    end
  end

  // walk registers double as the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x <= '0;
      walk_y <= '0;
      err    <= '0;
      span_x <= '0;
      span_y <= '0;
      dir    <= '0;
    end else if (in_fire) begin
      walk_x <= s_tdata[COORD_BITS-1:0];
      walk_y <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      err    <= setup_err;
      span_x <= setup_span_x;
      span_y <= setup_span_y;
      dir    <= setup_dir;
    end else if (out_fire && !m_tlast) begin
      walk_x <= walk_x_next;
      walk_y <= walk_y_next;
      err    <= err_next;
    end
  end

  `FCLS_ASSERT_IMPLY(a_no_overlap, clk, rst, m_tvalid, !s_tready, "request taken while emitting")
  `FCLS_ASSERT_NEXT(a_walk_continues, clk, rst, out_fire && !m_tlast, m_tvalid, "walk stopped early")
  `FCLS_ASSERT_NEXT(a_idle_after_last, clk, rst, out_fire && m_tlast, s_tready && !m_tvalid, "not idle after last cell")
  `FCLS_ASSERT_NEXT(a_steps_count, clk, rst, out_fire && !m_tlast, steps_left == $past(steps_left) - (COORD_BITS+1)'(1), "step count slip")

endmodule

`default_nettype wire

/* test/tb.sv */
// testbench for the four-connected line stepper: directed and random line requests
`timescale 1ns / 1ps

module tb;

  localparam int COORD_BITS = 5;

  // start_x in the lowest bits, matching the order of s_tdata
  typedef struct packed {
    logic       typed;
    logic [4:0] end_y;
    logic [4:0] end_x;
    logic [4:0] start_y;
    logic [4:0] start_x;
  } line_req_t;

  typedef struct packed {
    logic [4:0] x;
    logic [4:0] y;
    logic       last;
  } cell_t;

  localparam int NUM_ROWS = 20;
  localparam int NUM_RANDOM = 400;

  // typed rows have equal endpoints: one cell, the start, marked last
  line_req_t directed_rows [NUM_ROWS] = '{
    {1'b1, 5'd0,  5'd0,  5'd0,  5'd0},
    {1'b1, 5'd31, 5'd31, 5'd31, 5'd31},
    {1'b1, 5'd17, 5'd9,  5'd17, 5'd9},
    {1'b0, 5'd31, 5'd31, 5'd0,  5'd0},
    {1'b0, 5'd0,  5'd0,  5'd31, 5'd31},
    {1'b0, 5'd0,  5'd31, 5'd0,  5'd0},
    {1'b0, 5'd0,  5'd0,  5'd0,  5'd31},
    {1'b0, 5'd31, 5'd0,  5'd0,  5'd0},
    {1'b0, 5'd0,  5'd0,  5'd31, 5'd0},
    {1'b0, 5'd0,  5'd31, 5'd31, 5'd0},
    {1'b0, 5'd31, 5'd0,  5'd0,  5'd31},
    {1'b0, 5'd5,  5'd6,  5'd5,  5'd5},
    {1'b0, 5'd4,  5'd5,  5'd5,  5'd5},
    {1'b0, 5'd10, 5'd3,  5'd3,  5'd10},
    {1'b0, 5'd3,  5'd10, 5'd10, 5'd3},
    {1'b0, 5'd12, 5'd20, 5'd9,  5'd7},
    {1'b0, 5'd9,  5'd7,  5'd12, 5'd20},
    {1'b0, 5'd2,  5'd15, 5'd20, 5'd12},
    {1'b0, 5'd1,  5'd2,  5'd2,  5'd1},
    {1'b0, 5'd30, 5'd1,  5'd1,  5'd30}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // start_x, start_y, end_x, end_y from bit 0 up
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // cell_x, cell_y from bit 0 up
  logic [15:0] m_tdata;
  logic        m_tlast;

  cell_t pending_cells [$];
  cell_t want_cell;
  int    mismatches = 0;
  int    stall_left = 0;
  int    stall_pick;
  logic  quiet = 1'b0;

  four_connected_line_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // appends one expected cell at the tail of the queue
  task automatic queue_cell(input cell_t c);
    pending_cells.insert(pending_cells.size(), c);
  endtask

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // walks the line and queues every cell it passes
  task automatic trace_line(input line_req_t r);
    int         span_x;
    int         span_y;
    int         err;
    int         steps;
    logic       x_neg;
    logic       y_neg;
    logic [4:0] wx;
    logic [4:0] wy;
    span_x = (r.end_x >= r.start_x) ? r.end_x - r.start_x : r.start_x - r.end_x;
    span_y = (r.end_y >= r.start_y) ? r.end_y - r.start_y : r.start_y - r.end_y;
    x_neg = !(r.end_x > r.start_x);
    y_neg = !(r.end_y > r.start_y);
    err = span_x - span_y;
    steps = span_x + span_y;
    wx = r.start_x;
    wy = r.start_y;
    queue_cell({wx, wy, steps == 0});
    while (steps != 0) begin
      if (2 * err > -span_y) begin
        err = err - span_y;
        wx = x_neg ? wx - 5'd1 : wx + 5'd1;
      end else begin
        err = err + span_x;
        wy = y_neg ? wy - 5'd1 : wy + 5'd1;
      end
      steps--;
      queue_cell({wx, wy, steps == 0});
    end
  endtask

  function automatic logic [4:0] near_coord(input logic [4:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > 31) v = 31;
    return v[4:0];
  endfunction

  function automatic line_req_t random_request();
    line_req_t r;
    int        kind;
    r = '0;
    r.start_x = 5'($urandom_range(0, 31));
    r.start_y = 5'($urandom_range(0, 31));
    r.end_x = 5'($urandom_range(0, 31));
    r.end_y = 5'($urandom_range(0, 31));
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      r.end_x = near_coord(r.start_x);
      r.end_y = near_coord(r.start_y);
    end else if (kind == 2) begin
      r.end_y = r.start_y;
    end else if (kind == 3) begin
      r.end_x = r.start_x;
    end else if (kind == 4) begin
      // corners and equal endpoints
      r.start_x = {5{$urandom_range(0, 1) == 1}};
      r.start_y = {5{$urandom_range(0, 1) == 1}};
      if ($urandom_range(0, 1) == 1) begin
        r.end_x = r.start_x;
        r.end_y = r.start_y;
      end else begin
        r.end_x = {5{$urandom_range(0, 1) == 1}};
        r.end_y = {5{$urandom_range(0, 1) == 1}};
      end
    end
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_request(input line_req_t r);
    int gap;
    if ($urandom_range(0, 29) == 0) quiet = ~quiet;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, r[19:0]};
    do @(posedge clk); while (!s_tready);
    if (r.typed) queue_cell({r.start_x, r.start_y, 1'b1});
    else trace_line(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_pick = pick_gap();
      m_tready <= (stall_pick == 0);
      stall_left <= (stall_pick > 0) ? stall_pick - 1 : 0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cells.size() == 0) begin
        flag_mismatch($sformatf("unexpected cell x=%0d y=%0d last=%0d",
                                m_tdata[4:0], m_tdata[9:5], m_tlast));
      end else begin
        want_cell = pending_cells.pop_front();
        if (m_tdata[4:0] !== want_cell.x)
          flag_mismatch($sformatf("cell_x %0d, want %0d", m_tdata[4:0], want_cell.x));
        if (m_tdata[9:5] !== want_cell.y)
          flag_mismatch($sformatf("cell_y %0d, want %0d", m_tdata[9:5], want_cell.y));
        if (m_tlast !== want_cell.last)
          flag_mismatch($sformatf("last_cell %0d, want %0d", m_tlast, want_cell.last));
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_ROWS; i++) send_request(directed_rows[i]);
    for (int i = 0; i < NUM_RANDOM; i++) send_request(random_request());
    s_tvalid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // worst case is well under a fifth of this
  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
